>>> rtl/lbf_pkg.sv
// Shared types, codes and constants of the LED blink and fade controller.
`timescale 1ns / 1ps
`default_nettype none
package lbf_pkg;

    localparam int NUM_LEDS_DEF  = 8;
    localparam int TIME_BITS_DEF = 24;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0]  BLINK_FOREVER = 8'hFF;
    localparam logic [31:0] FADE_EPS      = 32'd16777;
    localparam logic [15:0] FULL_SCALE    = 16'd25600;

    localparam logic [2:0] KIND_TICK         = 3'd0;
    localparam logic [2:0] KIND_SET          = 3'd1;
    localparam logic [2:0] KIND_TOGGLE       = 3'd2;
    localparam logic [2:0] KIND_BLINK        = 3'd3;
    localparam logic [2:0] KIND_SMOOTH_SET   = 3'd4;
    localparam logic [2:0] KIND_SMOOTH_BLINK = 3'd5;
    localparam logic [2:0] KIND_QUERY        = 3'd6;
    localparam logic [2:0] KIND_UNUSED       = 3'd7;

    localparam logic [2:0] REG_DUTY_HIGH      = 3'd0;
    localparam logic [2:0] REG_DUTY_LOW       = 3'd1;
    localparam logic [2:0] REG_FADE_IN_ACCEL  = 3'd2;
    localparam logic [2:0] REG_FADE_OUT_ACCEL = 3'd3;
    localparam logic [2:0] REG_FADE_OUT_TICKS = 3'd4;
    localparam logic [2:0] REG_ACTIVE_LOW     = 3'd5;
    localparam logic [2:0] REG_DRIVE_GPIO     = 3'd6;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_FADE_IN    = 3'd1,
        MODE_FADE_OUT   = 3'd2,
        MODE_BLINK      = 3'd4,
        MODE_FADE_BLINK = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_SET,
        OP_TOGGLE,
        OP_BLINK,
        OP_SMOOTH_SET,
        OP_SMOOTH_BLINK,
        OP_QUERY,
        OP_BAD_KIND
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        bad_index;
        logic        timing_ok;
        logic [2:0]  led_index;
        logic        turn_on;
        logic [15:0] on_ticks;
        logic [15:0] period_ticks;
        logic [7:0]  blink_count;
    } cmd_t;

    typedef struct packed {
        logic [14:0] duty_high;
        logic [14:0] duty_low;
        logic [31:0] fade_in_accel;
        logic [31:0] fade_out_accel;
        logic [15:0] fade_out_ticks;
        logic        active_low;
        logic        drive_gpio;
    } cfg_t;

endpackage
`default_nettype wire

>>> rtl/lbf_front.sv
// Front end: decodes and classifies incoming beats into queued commands.
`timescale 1ns / 1ps
`default_nettype none
module lbf_front #(
    parameter int NUM_LEDS = lbf_pkg::NUM_LEDS_DEF
) (
    input  wire logic [2:0]  kind,
    input  wire logic [47:0] data,
    output lbf_pkg::cmd_t    cmd
);
    import lbf_pkg::*;

    always_comb
    begin
        cmd.led_index    = data[2:0];
        cmd.turn_on      = data[3];
        cmd.on_ticks     = data[19:4];
        cmd.period_ticks = data[35:20];
        cmd.blink_count  = data[43:36];
        cmd.bad_index    = (32'(data[2:0]) >= 32'(NUM_LEDS));
        cmd.timing_ok    = (data[19:4] < data[35:20]);
        case (kind)
            KIND_TICK:         cmd.op = OP_TICK;
            KIND_SET:          cmd.op = OP_SET;
            KIND_TOGGLE:       cmd.op = OP_TOGGLE;
            KIND_BLINK:        cmd.op = OP_BLINK;
            KIND_SMOOTH_SET:   cmd.op = OP_SMOOTH_SET;
            KIND_SMOOTH_BLINK: cmd.op = OP_SMOOTH_BLINK;
            KIND_QUERY:        cmd.op = OP_QUERY;
            default:           cmd.op = OP_BAD_KIND;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/lbf_queue.sv
// Short command queue between the front end and the channel engine.
`timescale 1ns / 1ps
`default_nettype none
module lbf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  lbf_pkg::cmd_t      push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output lbf_pkg::cmd_t      pop_data
);
    import lbf_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t           mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;

    assign full      = (count_reg == (PW + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/lbf_engine.sv
// Back end: per-channel state, tick and command execution, result register.
`timescale 1ns / 1ps
`default_nettype none
module lbf_engine #(
    parameter int NUM_LEDS  = lbf_pkg::NUM_LEDS_DEF,
    parameter int TIME_BITS = lbf_pkg::TIME_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  lbf_pkg::cfg_t    cfg,
    input  wire logic        cmd_valid,
    input  lbf_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    output logic             out_valid,
    output logic [47:0]      out_data,
    input  wire logic        out_ready
);
    import lbf_pkg::*;

    localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    mode_t                mode_reg     [NUM_LEDS];
    logic [31:0]          duty_reg     [NUM_LEDS];
    logic [TIME_BITS-1:0] fade_reg     [NUM_LEDS];
    logic [15:0]          phase_reg    [NUM_LEDS];
    logic [15:0]          bon_reg      [NUM_LEDS];
    logic [15:0]          bper_reg     [NUM_LEDS];
    logic [7:0]           bleft_reg    [NUM_LEDS];
    logic [TIME_BITS-1:0] ondur_reg    [NUM_LEDS];

    logic                 out_valid_reg;
    logic [47:0]          out_data_reg;

    logic [LW-1:0]        sel;
    mode_t                cur_mode, mode_next;
    logic [31:0]          cur_duty, duty_next;
    logic [TIME_BITS-1:0] cur_fade, fade_next;
    logic [15:0]          cur_phase, phase_next;
    logic [7:0]           cur_bleft, bleft_next;
    logic [15:0]          bon_next, bper_next;
    logic [TIME_BITS-1:0] cur_ondur, ondur_next;

    logic [31:0]          max_acc, min_acc, fade_floor;
    logic                 on_phase, in_dir, left_pos, wrap;
    logic [15:0]          left;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          prod;
    logic [64:0]          v_in;
    logic [31:0]          v_out;
    logic                 fade_ok;
    logic [31:0]          fade_val;
    logic [TIME_BITS-1:0] fade_inc;
    logic                 err;
    logic [15:0]          duty16;
    logic signed [17:0]   inv_duty;
    logic [14:0]          pwm;
    logic                 pin, full;
    logic [31:0]          ondur_wide;

    assign sel       = LW'(cmd.led_index);
    assign cmd_pop   = cmd_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cur_mode  = mode_reg[sel];
    assign cur_duty  = duty_reg[sel];
    assign cur_fade  = fade_reg[sel];
    assign cur_phase = phase_reg[sel];
    assign cur_bleft = bleft_reg[sel];
    assign cur_ondur = ondur_reg[sel];

    assign max_acc    = {1'b0, cfg.duty_high, 16'd0};
    assign min_acc    = {1'b0, cfg.duty_low, 16'd0};
    assign fade_floor = min_acc + FADE_EPS;

    always_comb
    begin
        on_phase = (cur_phase < bon_reg[sel]);
        in_dir   = (cur_mode == MODE_FADE_IN) || ((cur_mode == MODE_FADE_BLINK) && on_phase);
        left_pos = (32'(cfg.fade_out_ticks) > 32'(cur_fade));
        left     = cfg.fade_out_ticks - cur_fade[15:0];
        mul_a    = in_dir ? cfg.fade_in_accel : cfg.fade_out_accel;
        mul_b    = in_dir ? 32'(cur_fade) : 32'(left);
        prod     = 64'(mul_a) * 64'(mul_b);
        v_in     = 65'(cur_duty) + 65'(prod);
        v_out    = cur_duty - prod[31:0];
        fade_inc = (cur_fade < TIME_MAX) ? cur_fade + 1'b1 : cur_fade;
        if (in_dir)
        begin
            fade_ok  = (v_in <= 65'(max_acc));
            fade_val = fade_ok ? v_in[31:0] : max_acc;
        end
        else
        begin
            fade_ok  = left_pos && (prod < 64'(cur_duty)) && (v_out > fade_floor);
            fade_val = fade_ok ? v_out : min_acc;
        end
        wrap = (cur_phase >= bper_reg[sel]);
    end

    always_comb
    begin
        mode_next  = cur_mode;
        duty_next  = cur_duty;
        fade_next  = cur_fade;
        phase_next = cur_phase;
        bon_next   = bon_reg[sel];
        bper_next  = bper_reg[sel];
        bleft_next = cur_bleft;
        ondur_next = cur_ondur;
        err        = 1'b0;
        case (cmd.op)
            OP_TICK:
            begin
                case (cur_mode)
                    MODE_FADE_IN, MODE_FADE_OUT, MODE_FADE_BLINK:
                    begin
                        duty_next = fade_val;
                        fade_next = fade_ok ? fade_inc : '0;
                        if (!fade_ok && cur_mode != MODE_FADE_BLINK)
                        begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                    MODE_BLINK:
                    begin
                        duty_next = on_phase ? max_acc : min_acc;
                    end
                    default:
                    begin
                        duty_next = cur_duty;
                    end
                endcase
                if ((cur_mode == MODE_BLINK || cur_mode == MODE_FADE_BLINK)
                    && wrap && cur_bleft != BLINK_FOREVER)
                begin
                    if (cur_bleft == 8'd0)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    else
                    begin
                        bleft_next = cur_bleft - 1'b1;
                    end
                end
                phase_next = wrap ? 16'd0 : cur_phase + 1'b1;
                if ({duty_next, 1'b0} >= 33'(max_acc))
                begin
                    ondur_next = (cur_ondur < TIME_MAX) ? cur_ondur + 1'b1 : cur_ondur;
                end
                else
                begin
                    ondur_next = '0;
                end
            end
            OP_SET:
            begin
                mode_next = MODE_NORMAL;
                duty_next = cmd.turn_on ? max_acc : min_acc;
            end
            OP_TOGGLE:
            begin
                mode_next = MODE_NORMAL;
                duty_next = (cur_duty >= max_acc) ? min_acc : max_acc;
            end
            OP_BLINK, OP_SMOOTH_BLINK:
            begin
                if (cmd.timing_ok && cur_mode == MODE_NORMAL)
                begin
                    mode_next  = (cmd.op == OP_BLINK) ? MODE_BLINK : MODE_FADE_BLINK;
                    bon_next   = cmd.on_ticks;
                    bper_next  = cmd.period_ticks;
                    phase_next = 16'd0;
                    bleft_next = cmd.blink_count;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            OP_SMOOTH_SET:
            begin
                mode_next = cmd.turn_on ? MODE_FADE_IN : MODE_FADE_OUT;
            end
            OP_QUERY:
            begin
                err = 1'b0;
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        duty16   = duty_next[31:16];
        full     = (duty_next >= max_acc);
        inv_duty = $signed(18'(FULL_SCALE)) - $signed(18'(duty16));
        if (inv_duty < $signed(18'(cfg.duty_low)))
        begin
            inv_duty = $signed(18'(cfg.duty_low));
        end
        pwm        = cfg.drive_gpio ? 15'd0 : (cfg.active_low ? inv_duty[14:0] : duty16[14:0]);
        pin        = cfg.drive_gpio && (full ^ cfg.active_low);
        ondur_wide = 32'(ondur_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                mode_reg[i]  <= MODE_NORMAL;
                duty_reg[i]  <= '0;
                fade_reg[i]  <= '0;
                phase_reg[i] <= '0;
                bon_reg[i]   <= '0;
                bper_reg[i]  <= '0;
                bleft_reg[i] <= '0;
                ondur_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                out_valid_reg <= 1'b1;
                if (!cmd.bad_index)
                begin
                    mode_reg[sel]  <= mode_next;
                    duty_reg[sel]  <= duty_next;
                    fade_reg[sel]  <= fade_next;
                    phase_reg[sel] <= phase_next;
                    bon_reg[sel]   <= bon_next;
                    bper_reg[sel]  <= bper_next;
                    bleft_reg[sel] <= bleft_next;
                    ondur_reg[sel] <= ondur_next;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            if (cmd.bad_index)
            begin
                out_data_reg <= 48'd1;
            end
            else
            begin
                out_data_reg <= {5'd0, ondur_wide[23:0],
                                 (mode_next != MODE_NORMAL) || (duty_next != 32'd0),
                                 (mode_next == MODE_NORMAL), pin, pwm, err};
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/led_blink_fade_controller.sv
// Top level of the multi-channel LED blink and fade controller.
//
// Command beats arrive on the s_axis channel: tuser carries the kind of
// beat (tick, set, toggle, blink, smooth set, smooth blink, query) and
// tdata the channel number and command operands. Every beat yields one
// result beat on m_axis with the status and the channel's drive outputs.
// A front end decodes each beat into a two-entry queue; the channel engine
// takes one command per cycle while its result register is free or being
// taken, updates that channel's state and loads the result register. A
// result is registered through the queue and the result register; one beat
// per cycle is sustained while m_axis_tready is high.
// The engine's single fade multiplier and channel state update set that
// figure. When the receiver stalls, the result register holds and the
// queue fills; s_axis_tready falls once the queue is full.
// Shared limits, fade rates, polarity and drive type are set through the
// APB port. Reset empties the queue, restores register defaults and
// turns every channel off in normal mode.
`timescale 1ns / 1ps
`default_nettype none
module led_blink_fade_controller #(
    parameter int NUM_LEDS  = lbf_pkg::NUM_LEDS_DEF,
    parameter int TIME_BITS = lbf_pkg::TIME_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // led_index[2:0], turn_on[3], on_ticks[19:4], period_ticks[35:20], blink_count[43:36]
    input  wire logic [47:0] s_axis_tdata,
    // kind[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[0], pwm_duty[15:1], pin_level[16], idle[17], lit[18], active_ticks[42:19]
    output logic [47:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lbf_pkg::*;

    cfg_t       cfg_reg;
    cmd_t       front_cmd, queue_cmd;
    logic       queue_full, queue_has, queue_pop;
    logic [2:0] reg_index;

    assign pready        = 1'b1;
    assign reg_index     = paddr[4:2];
    assign s_axis_tready = !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_high      <= 15'd25600;
            cfg_reg.duty_low       <= 15'd0;
            cfg_reg.fade_in_accel  <= 32'd3355;
            cfg_reg.fade_out_accel <= 32'd3355;
            cfg_reg.fade_out_ticks <= 16'd100;
            cfg_reg.active_low     <= 1'b0;
            cfg_reg.drive_gpio     <= 1'b0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_index)
                REG_DUTY_HIGH:      cfg_reg.duty_high      <= pwdata[14:0];
                REG_DUTY_LOW:       cfg_reg.duty_low       <= pwdata[14:0];
                REG_FADE_IN_ACCEL:  cfg_reg.fade_in_accel  <= pwdata;
                REG_FADE_OUT_ACCEL: cfg_reg.fade_out_accel <= pwdata;
                REG_FADE_OUT_TICKS: cfg_reg.fade_out_ticks <= pwdata[15:0];
                REG_ACTIVE_LOW:     cfg_reg.active_low     <= pwdata[0];
                REG_DRIVE_GPIO:     cfg_reg.drive_gpio     <= pwdata[0];
                default:            cfg_reg.drive_gpio     <= cfg_reg.drive_gpio;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_DUTY_HIGH:      prdata = 32'(cfg_reg.duty_high);
            REG_DUTY_LOW:       prdata = 32'(cfg_reg.duty_low);
            REG_FADE_IN_ACCEL:  prdata = cfg_reg.fade_in_accel;
            REG_FADE_OUT_ACCEL: prdata = cfg_reg.fade_out_accel;
            REG_FADE_OUT_TICKS: prdata = 32'(cfg_reg.fade_out_ticks);
            REG_ACTIVE_LOW:     prdata = 32'(cfg_reg.active_low);
            REG_DRIVE_GPIO:     prdata = 32'(cfg_reg.drive_gpio);
            default:            prdata = 32'd0;
        endcase
    end

    lbf_front #(
        .NUM_LEDS (NUM_LEDS)
    ) u_front (
        .kind (s_axis_tuser),
        .data (s_axis_tdata),
        .cmd  (front_cmd)
    );

    lbf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid && s_axis_tready),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_has),
        .pop_data  (queue_cmd)
    );

    lbf_engine #(
        .NUM_LEDS  (NUM_LEDS),
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (queue_has),
        .cmd       (queue_cmd),
        .cmd_pop   (queue_pop),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_ready (m_axis_tready)
    );

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the LED blink and fade controller, with a built-in channel predictor.
`timescale 1ns / 1ps
module testbench;
    import lbf_pkg::*;

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  led;
        logic        turn_on;
        logic [15:0] on_ticks;
        logic [15:0] period_ticks;
        logic [7:0]  blink_count;
    } command_t;

    typedef struct {
        logic        status;
        logic [14:0] pwm_duty;
        logic        pin_level;
        logic        idle;
        logic        lit;
        logic [23:0] active_ticks;
    } led_report_t;

    localparam logic [31:0] TICKS_CAP = 32'hFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    led_blink_fade_controller u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor copy of the shared registers and per-channel state.
    logic [14:0] cfg_duty_high, cfg_duty_low;
    logic [31:0] cfg_fade_in_accel, cfg_fade_out_accel;
    logic [15:0] cfg_fade_out_ticks;
    logic        cfg_active_low, cfg_drive_gpio;

    mode_t       ch_mode [8];
    logic [31:0] ch_duty [8];
    logic [31:0] ch_fade_ticks [8];
    logic [15:0] ch_phase [8];
    logic [15:0] ch_on_ticks [8];
    logic [15:0] ch_period [8];
    logic [7:0]  ch_blinks_left [8];
    logic [31:0] ch_active [8];

    command_t    pending_cmds [$];
    led_report_t expected_reports [$];
    int          beats_in = 0;
    int          mismatches = 0;
    logic        in_taken = 1'b0;
    logic        hold_off = 1'b0;
    logic        quiet;

    assign quiet = (beats_in >= 400) && (beats_in < 600);

    function automatic longint unsigned full_acc();
        return longint'(cfg_duty_high) << 16;
    endfunction

    function automatic longint unsigned off_acc();
        return longint'(cfg_duty_low) << 16;
    endfunction

    function automatic void fade_up(int n, mode_t leave);
        longint unsigned v;
        v = longint'(ch_duty[n]) + longint'(cfg_fade_in_accel) * longint'(ch_fade_ticks[n]);
        if (v <= full_acc())
        begin
            ch_duty[n] = v[31:0];
            if (ch_fade_ticks[n] < TICKS_CAP)
                ch_fade_ticks[n]++;
        end
        else
        begin
            ch_duty[n] = 32'(full_acc());
            ch_fade_ticks[n] = 0;
            ch_mode[n] = leave;
        end
    endfunction

    function automatic void fade_down(int n, mode_t leave);
        longint left;
        longint v;
        left = longint'(cfg_fade_out_ticks) - longint'(ch_fade_ticks[n]);
        if (left > 0)
            v = longint'(ch_duty[n]) - longint'(cfg_fade_out_accel) * left;
        else
            v = longint'(off_acc());
        if (v > longint'(off_acc()) + longint'(FADE_EPS))
        begin
            ch_duty[n] = v[31:0];
            if (ch_fade_ticks[n] < TICKS_CAP)
                ch_fade_ticks[n]++;
        end
        else
        begin
            ch_duty[n] = 32'(off_acc());
            ch_fade_ticks[n] = 0;
            ch_mode[n] = leave;
        end
    endfunction

    function automatic void count_blinks(int n);
        if (ch_phase[n] >= ch_period[n] && ch_blinks_left[n] != BLINK_FOREVER)
        begin
            if (ch_blinks_left[n] == 0)
                ch_mode[n] = MODE_NORMAL;
            else
                ch_blinks_left[n]--;
        end
    endfunction

    function automatic void advance_channel(int n);
        logic on_phase;
        on_phase = ch_phase[n] < ch_on_ticks[n];
        case (ch_mode[n])
            MODE_FADE_IN: fade_up(n, MODE_NORMAL);
            MODE_FADE_OUT: fade_down(n, MODE_NORMAL);
            MODE_BLINK:
            begin
                ch_duty[n] = on_phase ? 32'(full_acc()) : 32'(off_acc());
                count_blinks(n);
            end
            MODE_FADE_BLINK:
            begin
                if (on_phase)
                    fade_up(n, MODE_FADE_BLINK);
                else
                    fade_down(n, MODE_FADE_BLINK);
                count_blinks(n);
            end
            default: ;
        endcase
        if (ch_phase[n] >= ch_period[n])
            ch_phase[n] = 0;
        else
            ch_phase[n]++;
        if (longint'(ch_duty[n]) * 2 >= full_acc())
        begin
            if (ch_active[n] < TICKS_CAP)
                ch_active[n]++;
        end
        else
            ch_active[n] = 0;
    endfunction

    function automatic led_report_t apply_command(command_t c);
        led_report_t r;
        int n;
        int duty;
        int d;
        n = c.led;
        r.status = 1'b0;
        case (c.kind)
            KIND_TICK: advance_channel(n);
            KIND_SET:
            begin
                ch_mode[n] = MODE_NORMAL;
                ch_duty[n] = c.turn_on ? 32'(full_acc()) : 32'(off_acc());
            end
            KIND_TOGGLE:
            begin
                ch_mode[n] = MODE_NORMAL;
                ch_duty[n] = (longint'(ch_duty[n]) >= full_acc()) ? 32'(off_acc())
                                                                  : 32'(full_acc());
            end
            KIND_BLINK, KIND_SMOOTH_BLINK:
            begin
                if (c.on_ticks < c.period_ticks && ch_mode[n] == MODE_NORMAL)
                begin
                    ch_mode[n] = (c.kind == KIND_BLINK) ? MODE_BLINK : MODE_FADE_BLINK;
                    ch_on_ticks[n] = c.on_ticks;
                    ch_period[n] = c.period_ticks;
                    ch_phase[n] = 0;
                    ch_blinks_left[n] = c.blink_count;
                end
                else
                    r.status = 1'b1;
            end
            KIND_SMOOTH_SET: ch_mode[n] = c.turn_on ? MODE_FADE_IN : MODE_FADE_OUT;
            KIND_QUERY: ;
            default: r.status = 1'b1;
        endcase
        duty = ch_duty[n] >> 16;
        r.pwm_duty = '0;
        r.pin_level = 1'b0;
        if (cfg_drive_gpio)
            r.pin_level = (longint'(ch_duty[n]) >= full_acc()) ^ cfg_active_low;
        else
        begin
            d = duty;
            if (cfg_active_low)
            begin
                d = int'(FULL_SCALE) - duty;
                if (d < int'(cfg_duty_low))
                    d = cfg_duty_low;
            end
            r.pwm_duty = d[14:0];
        end
        r.idle = ch_mode[n] == MODE_NORMAL;
        r.lit = ch_mode[n] != MODE_NORMAL || ch_duty[n] != 0;
        r.active_ticks = ch_active[n][23:0];
        return r;
    endfunction

    task automatic check_field(string name, longint expv, longint actv);
        if (expv != actv)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0d, got %0d", $realtime, name, expv, actv);
        end
    endtask

    always @(posedge clk)
    begin
        led_report_t want;
        command_t c;
        if (m_axis_tvalid && m_axis_tready && rst_n)
        begin
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected", $realtime);
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("status", want.status, m_axis_tdata[0]);
                check_field("pwm_duty", want.pwm_duty, m_axis_tdata[15:1]);
                check_field("pin_level", want.pin_level, m_axis_tdata[16]);
                check_field("idle", want.idle, m_axis_tdata[17]);
                check_field("lit", want.lit, m_axis_tdata[18]);
                check_field("active_ticks", want.active_ticks, m_axis_tdata[42:19]);
            end
        end
        if (s_axis_tvalid && s_axis_tready && rst_n)
        begin
            c.kind = s_axis_tuser;
            c.led = s_axis_tdata[2:0];
            c.turn_on = s_axis_tdata[3];
            c.on_ticks = s_axis_tdata[19:4];
            c.period_ticks = s_axis_tdata[35:20];
            c.blink_count = s_axis_tdata[43:36];
            expected_reports.push_back(apply_command(c));
            beats_in++;
        end
        in_taken <= s_axis_tvalid && s_axis_tready && rst_n;
    end

    always @(negedge clk)
    begin
        command_t c;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (pending_cmds.size() == 0 || (!quiet && $urandom_range(0, 99) < 30))
                s_axis_tvalid <= 1'b0;
            else
            begin
                c = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= c.kind;
                s_axis_tdata <= {4'b0, c.blink_count, c.period_ticks, c.on_ticks,
                                 c.turn_on, c.led};
            end
        end
        m_axis_tready <= rst_n && !hold_off && (quiet || $urandom_range(0, 99) >= 30);
    end

    initial
    begin
        while (beats_in < 800)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("testbench: errors");
        $finish;
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DUTY_HIGH: cfg_duty_high = value[14:0];
            REG_DUTY_LOW: cfg_duty_low = value[14:0];
            REG_FADE_IN_ACCEL: cfg_fade_in_accel = value;
            REG_FADE_OUT_ACCEL: cfg_fade_out_accel = value;
            REG_FADE_OUT_TICKS: cfg_fade_out_ticks = value[15:0];
            REG_ACTIVE_LOW: cfg_active_low = value[0];
            default: cfg_drive_gpio = value[0];
        endcase
    endtask

    task automatic write_all(logic [31:0] mx, logic [31:0] mn, logic [31:0] fin,
                             logic [31:0] fout, logic [31:0] fot, logic [31:0] al,
                             logic [31:0] gp);
        reg_write(REG_DUTY_HIGH, mx);
        reg_write(REG_DUTY_LOW, mn);
        reg_write(REG_FADE_IN_ACCEL, fin);
        reg_write(REG_FADE_OUT_ACCEL, fout);
        reg_write(REG_FADE_OUT_TICKS, fot);
        reg_write(REG_ACTIVE_LOW, al);
        reg_write(REG_DRIVE_GPIO, gp);
    endtask

    task automatic queue_cmd(logic [2:0] kind, logic [2:0] led, logic on,
                             logic [15:0] on_t, logic [15:0] per, logic [7:0] cnt);
        command_t c;
        c.kind = kind;
        c.led = led;
        c.turn_on = on;
        c.on_ticks = on_t;
        c.period_ticks = per;
        c.blink_count = cnt;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_random(int count);
        int r;
        logic [2:0] kind;
        logic [15:0] per;
        logic [15:0] on_t;
        logic [7:0] cnt;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 45) kind = KIND_TICK;
            else if (r < 52) kind = KIND_SET;
            else if (r < 58) kind = KIND_TOGGLE;
            else if (r < 68) kind = KIND_BLINK;
            else if (r < 78) kind = KIND_SMOOTH_SET;
            else if (r < 86) kind = KIND_SMOOTH_BLINK;
            else if (r < 97) kind = KIND_QUERY;
            else kind = KIND_UNUSED;
            per = 16'($urandom_range(1, 24));
            on_t = 16'($urandom_range(0, 32'(per) - 1));
            if ($urandom_range(0, 9) == 0)
            begin
                per = 16'($urandom);
                on_t = 16'($urandom);
            end
            r = $urandom_range(0, 9);
            cnt = (r < 6) ? 8'($urandom_range(0, 4)) : (r < 8) ? BLINK_FOREVER : 8'($urandom);
            queue_cmd(kind, 3'($urandom), 1'($urandom), on_t, per, cnt);
        end
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    initial
    begin
        cfg_duty_high = 15'd25600;
        cfg_duty_low = 15'd0;
        cfg_fade_in_accel = 32'd3355;
        cfg_fade_out_accel = 32'd3355;
        cfg_fade_out_ticks = 16'd100;
        cfg_active_low = 1'b0;
        cfg_drive_gpio = 1'b0;
        for (int n = 0; n < 8; n++)
        begin
            ch_mode[n] = MODE_NORMAL;
            ch_duty[n] = 0;
            ch_fade_ticks[n] = 0;
            ch_phase[n] = 0;
            ch_on_ticks[n] = 0;
            ch_period[n] = 0;
            ch_blinks_left[n] = 0;
            ch_active[n] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_cmd(KIND_SET, 3'd0, 1'b1, 16'd0, 16'd0, 8'd0);
        queue_cmd(KIND_TICK, 3'd0, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
        queue_cmd(KIND_TOGGLE, 3'd0, 1'b0, 16'd0, 16'd0, 8'd0);
        queue_cmd(KIND_QUERY, 3'd7, 1'b1, 16'd0, 16'd0, 8'd0);
        queue_cmd(KIND_BLINK, 3'd1, 1'b0, 16'd2, 16'd5, 8'd1);
        queue_cmd(KIND_BLINK, 3'd1, 1'b0, 16'd1, 16'd3, 8'd0);
        repeat (4) queue_cmd(KIND_TICK, 3'd1, 1'b0, 16'd0, 16'd0, 8'd0);
        queue_cmd(KIND_BLINK, 3'd2, 1'b0, 16'd5, 16'd5, 8'd1);
        queue_cmd(KIND_BLINK, 3'd2, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
        queue_cmd(KIND_SMOOTH_BLINK, 3'd2, 1'b0, 16'd0, 16'd0, 8'd0);
        queue_cmd(KIND_BLINK, 3'd6, 1'b0, 16'd0, 16'hFFFF, 8'd0);
        queue_cmd(KIND_TICK, 3'd6, 1'b0, 16'd0, 16'd0, 8'd0);
        queue_cmd(KIND_SMOOTH_SET, 3'd3, 1'b1, 16'd0, 16'd0, 8'd0);
        repeat (3) queue_cmd(KIND_TICK, 3'd3, 1'b0, 16'd0, 16'd0, 8'd0);
        queue_cmd(KIND_SMOOTH_SET, 3'd3, 1'b0, 16'd0, 16'd0, 8'd0);
        queue_cmd(KIND_TICK, 3'd3, 1'b0, 16'd0, 16'd0, 8'd0);
        queue_cmd(KIND_SMOOTH_BLINK, 3'd4, 1'b0, 16'd1, 16'd4, BLINK_FOREVER);
        queue_cmd(KIND_TICK, 3'd4, 1'b0, 16'd0, 16'd0, 8'd0);
        queue_cmd(KIND_UNUSED, 3'd5, 1'b1, 16'd0, 16'd0, 8'd0);
        queue_random(200);
        drain();

        write_all(25600, 0, 32'h40_0000, 32'h40_0000, 30, 0, 0);
        queue_random(205);
        drain();
        write_all(20000, 1000, 32'hFFFF_FFFF, 0, 0, 1, 0);
        queue_random(205);
        drain();
        write_all(25600, 25600, 0, 32'hFFFF_FFFF, 65535, 1, 1);
        queue_random(205);
        drain();
        write_all(0, 0, 12345, 777777, 5, 0, 1);
        queue_random(205);
        drain();
        write_all(25600, 0, 32'h20_0000, 32'h30_0000, 40, 0, 0);
        queue_random(205);
        drain();

        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/lbf_pkg.sv
rtl/lbf_front.sv
rtl/lbf_queue.sv
rtl/lbf_engine.sv
rtl/led_blink_fade_controller.sv
verif/testbench.sv
